// ----- sv/average_consensus_node_update_unit_macros.svh -----
// Assertion macros shared by the consensus node RTL.
// Each macro takes a label, a property expression and a message string.
`ifndef AVERAGE_CONSENSUS_NODE_UPDATE_UNIT_MACROS_SVH
`define AVERAGE_CONSENSUS_NODE_UPDATE_UNIT_MACROS_SVH

`ifndef NO_ASSERTIONS

// The property must hold at every clock edge outside reset.
`define ACNU_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// The condition must never be true outside reset.
`define ACNU_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`else

`define ACNU_ASSERT(lbl, prop, msg)

`define ACNU_ASSERT_NEVER(lbl, cond, msg)

`endif

`endif

// ----- sv/acnu_pkg.sv -----
`timescale 1ns / 1ps

package acnu_pkg;

  // Request kinds on the input channel.
  typedef enum logic [1:0] {
    KIND_STORE  = 2'd0,
    KIND_INIT   = 2'd1,
    KIND_UPDATE = 2'd2
  } kind_e;

  // Configuration register indexes.
  localparam logic [1:0] CFG_ADJACENCY = 2'd0;
  localparam logic [1:0] CFG_SELF      = 2'd1;
  localparam logic [1:0] CFG_MIN_TEMP  = 2'd2;

  localparam logic signed [31:0] MIN_TEMP_RESET = -32'sd2621440;

  localparam int unsigned WEIGHT_W = 17;
  localparam int unsigned STATE_W  = 32;
  localparam int unsigned PROD_W   = WEIGHT_W + 1 + STATE_W;

  localparam logic [WEIGHT_W-1:0] ONE_Q16 = 17'h10000;

  // round(65536 / d), halves up, for d = 1 .. 8.
  function automatic logic [WEIGHT_W-1:0] recip_q16(logic [3:0] d);
    logic [WEIGHT_W-1:0] r;
    case (d)
      4'd1:    r = 17'd65536;
      4'd2:    r = 17'd32768;
      4'd3:    r = 17'd21845;
      4'd4:    r = 17'd16384;
      4'd5:    r = 17'd13107;
      4'd6:    r = 17'd10923;
      4'd7:    r = 17'd9362;
      4'd8:    r = 17'd8192;
      default: r = '0;
    endcase
    return r;
  endfunction

  // round(n * 65536 / d), halves up, for 0 <= n < d <= 8.
  function automatic logic [WEIGHT_W-1:0] frac_q16(logic [2:0] n, logic [3:0] d);
    logic [WEIGHT_W-1:0] r;
    case ({d, n})
      {4'd2, 3'd1}: r = 17'd32768;
      {4'd3, 3'd1}: r = 17'd21845;
      {4'd3, 3'd2}: r = 17'd43691;
      {4'd4, 3'd1}: r = 17'd16384;
      {4'd4, 3'd2}: r = 17'd32768;
      {4'd4, 3'd3}: r = 17'd49152;
      {4'd5, 3'd1}: r = 17'd13107;
      {4'd5, 3'd2}: r = 17'd26214;
      {4'd5, 3'd3}: r = 17'd39322;
      {4'd5, 3'd4}: r = 17'd52429;
      {4'd6, 3'd1}: r = 17'd10923;
      {4'd6, 3'd2}: r = 17'd21845;
      {4'd6, 3'd3}: r = 17'd32768;
      {4'd6, 3'd4}: r = 17'd43691;
      {4'd6, 3'd5}: r = 17'd54613;
      {4'd7, 3'd1}: r = 17'd9362;
      {4'd7, 3'd2}: r = 17'd18725;
      {4'd7, 3'd3}: r = 17'd28087;
      {4'd7, 3'd4}: r = 17'd37449;
      {4'd7, 3'd5}: r = 17'd46811;
      {4'd7, 3'd6}: r = 17'd56174;
      {4'd8, 3'd1}: r = 17'd8192;
      {4'd8, 3'd2}: r = 17'd16384;
      {4'd8, 3'd3}: r = 17'd24576;
      {4'd8, 3'd4}: r = 17'd32768;
      {4'd8, 3'd5}: r = 17'd40960;
      {4'd8, 3'd6}: r = 17'd49152;
      {4'd8, 3'd7}: r = 17'd57344;
      default:      r = '0;
    endcase
    return r;
  endfunction

endpackage

// ----- sv/average_consensus_node_update_unit.sv -----
`timescale 1ns / 1ps
// One node of distributed average consensus with max-degree weights, signed Q16.16 states
// and Q1.16 weights. The block takes one request at a time. A store request (kind 0), an
// unused kind or a refused initialization (temperature below the configured minimum) goes
// straight to reading the own state and loading the output register. An accepted
// initialization (kind 1) first scans the adjacency rows for the degrees and fills the
// weights, and an update step (kind 2) runs the weighted sum and writes back the own state,
// before the same read and load. The single read port of the state and weight memories
// serves one node per cycle during the weighted sum, and the degree scan and weight fill
// each handle one node per cycle. A result sits in an output register, so a new request is
// accepted while the previous result waits to be taken. Configuration writes are accepted
// at any time but must only be issued while the block is idle. There is no clearing pass
// after reset: per-entry valid bits make never-written entries read as zero.

`include "average_consensus_node_update_unit_macros.svh"

module average_consensus_node_update_unit
  import acnu_pkg::*;
#(
  parameter int unsigned BOARD_COUNT = 8
) (
  input  logic               clk_i,
  input  logic               rst_ni,

  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [1:0]         cfg_index_i,
  input  logic [63:0]        cfg_data_i,

  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [1:0]         in_kind_i,
  input  logic [2:0]         in_board_index_i,
  input  logic signed [31:0] in_sample_value_i,

  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [31:0] out_own_state_o,
  output logic [31:0]        out_iteration_count_o,
  output logic               out_status_o
);

  localparam int unsigned IDX_W     = $clog2(BOARD_COUNT);
  localparam int unsigned D_W       = IDX_W + 1;
  localparam int unsigned ADJ_W     = BOARD_COUNT * BOARD_COUNT;
  localparam int unsigned ADJ_IDX_W = $clog2(ADJ_W);
  localparam int unsigned CNT_W     = $clog2(BOARD_COUNT + 2);
  localparam int unsigned ACC_W     = PROD_W + IDX_W;
  localparam int unsigned SHR_W     = ACC_W - 16;

  // Sequencer states.
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_DEG  = 3'd1;  // scan one adjacency row per cycle
  localparam logic [2:0] S_WGT  = 3'd2;  // write one weight per cycle
  localparam logic [2:0] S_MAC  = 3'd3;  // read, multiply, accumulate
  localparam logic [2:0] S_WB   = 3'd4;  // round, saturate, write back own state
  localparam logic [2:0] S_RD   = 3'd5;  // read own state for the result
  localparam logic [2:0] S_FIN  = 3'd6;  // load the output register

  // Configuration registers.
  logic [ADJ_W-1:0]   adj_q;
  logic [2:0]         self_index_q;
  logic signed [31:0] min_temp_q;

  // Control and working registers.
  logic [2:0]              state_q, state_d;
  logic [IDX_W-1:0]        row_q, row_d;
  logic [IDX_W-1:0]        g_q, g_d;
  logic [IDX_W-1:0]        degself_q, degself_d;
  logic [CNT_W-1:0]        cnt_q, cnt_d;
  logic signed [31:0]      sample_q, sample_d;
  logic                    status_q, status_d;
  logic [31:0]             iter_q, iter_d;
  logic signed [ACC_W-1:0] acc_q, acc_d;
  logic signed [PROD_W-1:0] prod_q;
  logic                    rd_pend_q;
  logic                    prod_vld_q;

  // Output register.
  logic               out_valid_q;
  logic signed [31:0] out_state_q;
  logic [31:0]        out_iter_q;
  logic               out_status_q;

  // Memories: node states and edge weights, one synchronous read port each.
  logic signed [31:0]  st_mem [BOARD_COUNT];
  logic [WEIGHT_W-1:0] wt_mem [BOARD_COUNT];
  logic [BOARD_COUNT-1:0] st_vld_q;
  logic [BOARD_COUNT-1:0] wt_vld_q;
  logic signed [31:0]  st_rdata_q;
  logic [WEIGHT_W-1:0] wt_rdata_q;
  logic                st_rvld_q;
  logic                wt_rvld_q;

  logic                st_we;
  logic [IDX_W-1:0]    st_waddr;
  logic signed [31:0]  st_wdata;
  logic                wt_we;
  logic [WEIGHT_W-1:0] wt_wdata;
  logic [IDX_W-1:0]    raddr;

  logic                 in_fire;
  logic [IDX_W-1:0]     self_slot;
  logic [BOARD_COUNT-1:0] row_bits;
  logic [IDX_W-1:0]     deg_row;
  logic [D_W-1:0]       d_val;
  logic [ADJ_IDX_W-1:0] self_bit;
  logic signed [PROD_W-1:0] prod_full;
  logic [WEIGHT_W-1:0]  w_eff;
  logic signed [31:0]   s_eff;
  logic signed [ACC_W-1:0] acc_rnd;
  logic signed [SHR_W-1:0] acc_shr;
  logic signed [31:0]   wb_value;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = (state_q == S_IDLE);
  assign in_fire     = in_valid_i && in_ready_o;

  assign out_valid_o           = out_valid_q;
  assign out_own_state_o       = out_state_q;
  assign out_iteration_count_o = out_iter_q;
  assign out_status_o          = out_status_q;

  // An out-of-range self index saturates to the last node.
  assign self_slot = ({1'b0, self_index_q} >= 4'(BOARD_COUNT)) ?
                     IDX_W'(BOARD_COUNT - 1) : self_index_q[IDX_W-1:0];

  // Degree of the row under scan, ignoring the diagonal.
  assign row_bits = adj_q[ADJ_IDX_W'(row_q) * ADJ_IDX_W'(BOARD_COUNT) +: BOARD_COUNT];

  always_comb begin
    deg_row = '0;
    for (int j = 0; j < BOARD_COUNT; j++) begin
      if ((IDX_W'(j) != row_q) && row_bits[j]) begin
        deg_row = deg_row + IDX_W'(1);
      end
    end
  end

  // Weight for the column being filled: the self slot gets one minus its share, a
  // neighbor of this node gets 1/D, everything else zero.
  assign d_val    = D_W'(g_q) + D_W'(1);
  assign self_bit = ADJ_IDX_W'(self_slot) * ADJ_IDX_W'(BOARD_COUNT) + ADJ_IDX_W'(row_q);

  always_comb begin
    if (row_q == self_slot) begin
      wt_wdata = ONE_Q16 - frac_q16(3'(degself_q), 4'(d_val));
    end else if (adj_q[self_bit]) begin
      wt_wdata = recip_q16(4'(d_val));
    end else begin
      wt_wdata = '0;
    end
  end

  // Entries never written read as zero.
  assign w_eff     = wt_rvld_q ? wt_rdata_q : '0;
  assign s_eff     = st_rvld_q ? st_rdata_q : '0;
  assign prod_full = $signed({1'b0, w_eff}) * s_eff;

  // Round to nearest with halves up, then saturate to 32 bits.
  assign acc_rnd = acc_q + ACC_W'(32768);
  assign acc_shr = SHR_W'(acc_rnd >>> 16);

  always_comb begin
    if ((&acc_shr[SHR_W-1:31]) || !(|acc_shr[SHR_W-1:31])) begin
      wb_value = acc_shr[31:0];
    end else if (acc_shr[SHR_W-1]) begin
      wb_value = 32'sh8000_0000;
    end else begin
      wb_value = 32'sh7fff_ffff;
    end
  end

  // Memory port control.
  always_comb begin
    st_we    = 1'b0;
    st_waddr = self_slot;
    st_wdata = sample_q;
    wt_we    = 1'b0;
    raddr    = self_slot;
    case (state_q)
      S_IDLE: begin
        if (in_fire && (in_kind_i == KIND_STORE) &&
            ({1'b0, in_board_index_i} < 4'(BOARD_COUNT))) begin
          st_we    = 1'b1;
          st_waddr = in_board_index_i[IDX_W-1:0];
          st_wdata = in_sample_value_i;
        end
      end
      S_WGT: begin
        wt_we = 1'b1;
        st_we = (row_q == IDX_W'(BOARD_COUNT - 1));
      end
      S_MAC: begin
        if (cnt_q < CNT_W'(BOARD_COUNT)) begin
          raddr = cnt_q[IDX_W-1:0];
        end
      end
      S_WB: begin
        st_we    = 1'b1;
        st_wdata = wb_value;
      end
      default: begin
      end
    endcase
  end

  // Sequencer.
  always_comb begin
    state_d   = state_q;
    row_d     = row_q;
    g_d       = g_q;
    degself_d = degself_q;
    cnt_d     = cnt_q;
    sample_d  = sample_q;
    status_d  = status_q;
    iter_d    = iter_q;
    acc_d     = acc_q;
    case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          sample_d = in_sample_value_i;
          status_d = 1'b0;
          row_d    = '0;
          g_d      = '0;
          cnt_d    = '0;
          acc_d    = '0;
          state_d  = S_RD;
          case (in_kind_i)
            KIND_INIT: begin
              if (in_sample_value_i < min_temp_q) begin
                status_d = 1'b1;
              end else begin
                state_d = S_DEG;
              end
            end
            KIND_UPDATE: begin
              state_d = S_MAC;
            end
            default: begin
            end
          endcase
        end
      end
      S_DEG: begin
        if (deg_row > g_q) begin
          g_d = deg_row;
        end
        if (row_q == self_slot) begin
          degself_d = deg_row;
        end
        if (row_q == IDX_W'(BOARD_COUNT - 1)) begin
          row_d   = '0;
          state_d = S_WGT;
        end else begin
          row_d = row_q + IDX_W'(1);
        end
      end
      S_WGT: begin
        if (row_q == IDX_W'(BOARD_COUNT - 1)) begin
          iter_d  = '0;
          state_d = S_RD;
        end else begin
          row_d = row_q + IDX_W'(1);
        end
      end
      S_MAC: begin
        if (prod_vld_q) begin
          acc_d = acc_q + ACC_W'(prod_q);
        end
        if (cnt_q == CNT_W'(BOARD_COUNT + 1)) begin
          state_d = S_WB;
        end else begin
          cnt_d = cnt_q + CNT_W'(1);
        end
      end
      S_WB: begin
        iter_d  = iter_q + 32'd1;
        state_d = S_RD;
      end
      S_RD: begin
        state_d = S_FIN;
      end
      S_FIN: begin
        if (!out_valid_q || out_ready_i) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control state and valid bits.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      adj_q        <= '0;
      self_index_q <= '0;
      min_temp_q   <= MIN_TEMP_RESET;
      iter_q       <= '0;
      st_vld_q     <= '0;
      wt_vld_q     <= '0;
      st_rvld_q    <= 1'b0;
      wt_rvld_q    <= 1'b0;
      rd_pend_q    <= 1'b0;
      prod_vld_q   <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      iter_q  <= iter_d;
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          CFG_ADJACENCY: adj_q        <= cfg_data_i[ADJ_W-1:0];
          CFG_SELF:      self_index_q <= cfg_data_i[2:0];
          CFG_MIN_TEMP:  min_temp_q   <= $signed(cfg_data_i[31:0]);
          default: begin
          end
        endcase
      end
      if (st_we) begin
        st_vld_q[st_waddr] <= 1'b1;
      end
      if (wt_we) begin
        wt_vld_q[row_q] <= 1'b1;
      end
      st_rvld_q  <= st_vld_q[raddr];
      wt_rvld_q  <= wt_vld_q[raddr];
      rd_pend_q  <= (state_q == S_MAC) && (cnt_q < CNT_W'(BOARD_COUNT));
      prod_vld_q <= rd_pend_q;
      if ((state_q == S_FIN) && (!out_valid_q || out_ready_i)) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Working and payload registers.
  always_ff @(posedge clk_i) begin
    row_q     <= row_d;
    g_q       <= g_d;
    degself_q <= degself_d;
    cnt_q     <= cnt_d;
    sample_q  <= sample_d;
    status_q  <= status_d;
    acc_q     <= acc_d;
    prod_q    <= prod_full;
    if ((state_q == S_FIN) && (!out_valid_q || out_ready_i)) begin
      out_state_q  <= s_eff;
      out_iter_q   <= iter_q;
      out_status_q <= status_q;
    end
  end

  // State and weight memories.
  always_ff @(posedge clk_i) begin
    if (st_we) begin
      st_mem[st_waddr] <= st_wdata;
    end
    st_rdata_q <= st_mem[raddr];
  end

  always_ff @(posedge clk_i) begin
    if (wt_we) begin
      wt_mem[row_q] <= wt_wdata;
    end
    wt_rdata_q <= wt_mem[raddr];
  end

  // Products are only accumulated while the weighted sum runs.
  `ACNU_ASSERT_NEVER(a_prod_outside_mac, prod_vld_q && (state_q != S_MAC), "stray product")

  // The self degree can never exceed the graph degree, or the self weight goes wrong.
  `ACNU_ASSERT(a_deg_bound, (state_q == S_WGT) |-> (degself_q <= g_q), "self degree above max")

  // Each write-back step advances the iteration count by exactly one.
  `ACNU_ASSERT(a_iter_step, (state_q == S_WB) |=> (iter_q == $past(iter_q) + 32'd1), "count step")

  // A request is never accepted while a result is being formed.
  `ACNU_ASSERT_NEVER(a_busy_accept, in_fire && (state_q == S_FIN), "accept while busy")

endmodule
